// ===== hdl/bda_pkg.sv =====
`timescale 1ns / 1ps

package bda_pkg;

    localparam int RAW_W    = 4;
    localparam int LEVEL_W  = 8;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET  = 8'd60;
    localparam logic [COUNT_W-1:0] DELAY_RESET  = 16'd2600;
    localparam logic [COUNT_W-1:0] RELOAD_RESET = 16'd1716;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_LEVEL = 2'd0,
        CFG_REPEAT_DELAY   = 2'd1,
        CFG_REPEAT_RELOAD  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic at_top;
        logic at_bottom;
        logic repeat_fire;
    } btn_status_t;

endpackage

// ===== hdl/button_debounce_autorepeat.sv =====
`timescale 1ns / 1ps

// debouncer with auto-repeat for a row of push buttons
// input channel: one transfer per sampling tick, raw_buttons bit i high = button i pressed
// output channel: one transfer per input transfer with pressed, released and held masks
// a pressed bit marks a new debounced press or an auto-repeat, released a debounced release
// result: registered in a result register, valid in the cycle after its input transfer
// throughput: one item per cycle while the receiver takes results; each button's integrator
// and repeat counter update through compare and increment logic
// stall: in_ready stays high while the result register is empty or is being taken;
// while the receiver holds out_ready low with a result waiting, no input is taken
// configuration: cfg_index 0 debounce level, 1 repeat delay, 2 repeat reload;
// other indexes are ignored; cfg_ready is always high, write only while idle
// reset: integrators, repeat counters and debounced state clear, output is empty,
// registers return to level 60, delay 2600, reload 1716
module button_debounce_autorepeat
#(
    parameter int NUM_BUTTONS = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bda_pkg::RAW_W-1:0]         raw_buttons,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bda_pkg::RAW_W-1:0]         pressed_mask,
    output logic [bda_pkg::RAW_W-1:0]         released_mask,
    output logic [bda_pkg::RAW_W-1:0]         held_mask,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bda_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [bda_pkg::LEVEL_W-1:0] level_reg;
    logic [bda_pkg::COUNT_W-1:0] delay_reg;
    logic [bda_pkg::COUNT_W-1:0] reload_reg;

    logic                        out_valid_reg;
    logic [bda_pkg::RAW_W-1:0]   pressed_reg;
    logic [bda_pkg::RAW_W-1:0]   released_reg;
    logic [bda_pkg::RAW_W-1:0]   held_reg;
    logic [bda_pkg::RAW_W-1:0]   pressed_next;
    logic [bda_pkg::RAW_W-1:0]   released_next;
    logic [bda_pkg::RAW_W-1:0]   held_out_next;

    logic [NUM_BUTTONS-1:0]      debounced_reg;
    logic [NUM_BUTTONS-1:0]      debounced_next;
    logic [NUM_BUTTONS-1:0]      top;
    logic [NUM_BUTTONS-1:0]      bottom;
    logic [NUM_BUTTONS-1:0]      repeats;
    logic [NUM_BUTTONS-1:0]      press_all;
    logic [NUM_BUTTONS-1:0]      release_all;

    logic                        in_xfer;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= bda_pkg::LEVEL_RESET;
            delay_reg  <= bda_pkg::DELAY_RESET;
            reload_reg <= bda_pkg::RELOAD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bda_pkg::CFG_DEBOUNCE_LEVEL: level_reg  <= cfg_data[bda_pkg::LEVEL_W-1:0];
                bda_pkg::CFG_REPEAT_DELAY:   delay_reg  <= cfg_data;
                bda_pkg::CFG_REPEAT_RELOAD:  reload_reg <= cfg_data;
                default:                     level_reg  <= level_reg;
            endcase
        end
    end

    // per-button integrator and repeat counter
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_btn
        logic                 raw_bit;
        bda_pkg::btn_status_t st;

        if (i < bda_pkg::RAW_W)
        begin : g_raw
            assign raw_bit = raw_buttons[i];
        end
        else
        begin : g_none
            assign raw_bit = 1'b0;
        end

        bda_button u_button
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (in_xfer),
            .raw     (raw_bit),
            .level   (level_reg),
            .delay   (delay_reg),
            .reload  (reload_reg),
            .status  (st)
        );

        assign top[i]     = st.at_top;
        assign bottom[i]  = st.at_bottom;
        assign repeats[i] = st.repeat_fire;
    end

    assign debounced_next = top | (~bottom & debounced_reg);
    assign press_all      = repeats | (debounced_next & ~debounced_reg);
    assign release_all    = ~debounced_next & debounced_reg;

    for (genvar j = 0; j < bda_pkg::RAW_W; j++)
    begin : g_out
        if (j < NUM_BUTTONS)
        begin : g_live
            assign pressed_next[j]  = press_all[j];
            assign released_next[j] = release_all[j];
            assign held_out_next[j] = debounced_next[j];
        end
        else
        begin : g_zero
            assign pressed_next[j]  = 1'b0;
            assign released_next[j] = 1'b0;
            assign held_out_next[j] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounced_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                debounced_reg <= debounced_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            held_reg     <= held_out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pressed_mask  = pressed_reg;
    assign released_mask = released_reg;
    assign held_mask     = held_reg;

endmodule

// ===== hdl/bda_button.sv =====
`timescale 1ns / 1ps

module bda_button
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               raw,
    input  logic [bda_pkg::LEVEL_W-1:0]        level,
    input  logic [bda_pkg::COUNT_W-1:0]        delay,
    input  logic [bda_pkg::COUNT_W-1:0]        reload,
    output bda_pkg::btn_status_t               status
);

    logic [bda_pkg::LEVEL_W-1:0] integ_reg;
    logic [bda_pkg::LEVEL_W-1:0] integ_next;
    logic [bda_pkg::COUNT_W-1:0] count_reg;
    logic [bda_pkg::COUNT_W-1:0] count_next;

    always_comb
    begin
        integ_next = integ_reg;
        if (raw)
        begin
            if (integ_reg < level)
            begin
                integ_next = integ_reg + 1'b1;
            end
        end
        else if (integ_reg != '0)
        begin
            integ_next = integ_reg - 1'b1;
        end
    end

    always_comb
    begin
        status.at_top      = (integ_next == level);
        status.at_bottom   = (integ_next == '0);
        status.repeat_fire = 1'b0;
        count_next         = count_reg;
        if (status.at_top)
        begin
            if (count_reg < delay)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                count_next         = reload;
                status.repeat_fire = 1'b1;
            end
        end
        if (status.at_bottom)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            integ_reg <= integ_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== test/button_debounce_autorepeat_test.sv =====
`timescale 1ns / 1ps

module button_debounce_autorepeat_test;

    typedef logic [bda_pkg::RAW_W-1:0]   raw_t;
    typedef logic [bda_pkg::LEVEL_W-1:0] level_t;
    typedef logic [bda_pkg::COUNT_W-1:0] count_t;

    localparam int                            TOTAL_ITEMS = 1100;
    localparam int                            STALL_LIMIT = 2000;
    localparam int                            HOLD_CYCLES = 200;
    localparam int                            MAX_PRINTED = 100;
    localparam logic [bda_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
    localparam raw_t                          ALL_PRESSED = '1;
    localparam raw_t                          NONE_PRESSED = '0;

    typedef struct packed {
        logic [bda_pkg::RAW_W-1:0] pressed;
        logic [bda_pkg::RAW_W-1:0] released;
        logic [bda_pkg::RAW_W-1:0] held;
    } tick_masks_t;

    class button_scoreboard;
        logic [bda_pkg::LEVEL_W-1:0] level;
        logic [bda_pkg::COUNT_W-1:0] delay;
        logic [bda_pkg::COUNT_W-1:0] reload;
        logic [bda_pkg::LEVEL_W-1:0] integ [bda_pkg::RAW_W];
        logic [bda_pkg::COUNT_W-1:0] rpt_count [bda_pkg::RAW_W];
        logic [bda_pkg::RAW_W-1:0]   held_state;
        tick_masks_t                 pending_masks [$];
        int                          errors;
        int                          ticks_checked;

        function new();
            level      = bda_pkg::LEVEL_RESET;
            delay      = bda_pkg::DELAY_RESET;
            reload     = bda_pkg::RELOAD_RESET;
            held_state = '0;
            errors     = 0;
            ticks_checked = 0;
            for (int i = 0; i < bda_pkg::RAW_W; i++)
            begin
                integ[i]     = '0;
                rpt_count[i] = '0;
            end
        endfunction

        function void write_reg(logic [bda_pkg::CFG_IDX_W-1:0] idx,
                                logic [bda_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bda_pkg::CFG_DEBOUNCE_LEVEL: level  = data[bda_pkg::LEVEL_W-1:0];
                bda_pkg::CFG_REPEAT_DELAY:   delay  = data[bda_pkg::COUNT_W-1:0];
                bda_pkg::CFG_REPEAT_RELOAD:  reload = data[bda_pkg::COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_masks.size();
        endfunction

        function void note_tick(logic [bda_pkg::RAW_W-1:0] raw);
            logic [bda_pkg::RAW_W-1:0] top;
            logic [bda_pkg::RAW_W-1:0] bottom;
            logic [bda_pkg::RAW_W-1:0] repeats;
            logic [bda_pkg::RAW_W-1:0] held;
            tick_masks_t               m;
            top     = '0;
            bottom  = '0;
            repeats = '0;
            for (int i = 0; i < bda_pkg::RAW_W; i++)
            begin
                if (raw[i])
                begin
                    if (integ[i] < level)
                        integ[i] = integ[i] + 1'b1;
                end
                else if (integ[i] != '0)
                    integ[i] = integ[i] - 1'b1;
                if (integ[i] == level)
                begin
                    if (rpt_count[i] < delay)
                        rpt_count[i] = rpt_count[i] + 1'b1;
                    else
                    begin
                        rpt_count[i] = reload;
                        repeats[i]   = 1'b1;
                    end
                    top[i] = 1'b1;
                end
                if (integ[i] == '0)
                begin
                    rpt_count[i] = '0;
                    bottom[i]    = 1'b1;
                end
            end
            held       = top | (~bottom & held_state);
            m.pressed  = repeats | (held & ~held_state);
            m.released = ~held & held_state;
            m.held     = held;
            held_state = held;
            pending_masks.push_back(m);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("mismatch at tick %0d: %s", ticks_checked, msg);
            errors++;
        endtask

        task check_tick(logic [bda_pkg::RAW_W-1:0] p, logic [bda_pkg::RAW_W-1:0] r,
                        logic [bda_pkg::RAW_W-1:0] h);
            tick_masks_t m;
            if (pending_masks.size() == 0)
            begin
                report($sformatf("unexpected result pressed %h released %h held %h", p, r, h));
                return;
            end
            m = pending_masks.pop_front();
            if (p !== m.pressed)
                report($sformatf("pressed_mask %h, want %h", p, m.pressed));
            if (r !== m.released)
                report($sformatf("released_mask %h, want %h", r, m.released));
            if (h !== m.held)
                report($sformatf("held_mask %h, want %h", h, m.held));
            ticks_checked++;
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [bda_pkg::RAW_W-1:0]      raw_buttons;
    logic                           out_valid;
    logic                           out_ready;
    logic [bda_pkg::RAW_W-1:0]      pressed_mask;
    logic [bda_pkg::RAW_W-1:0]      released_mask;
    logic [bda_pkg::RAW_W-1:0]      held_mask;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bda_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bda_pkg::CFG_DATA_W-1:0] cfg_data;

    button_scoreboard sb = new();

    int          items_sent;
    int          cycle_count;
    int          stall_cycles;
    bit          hold_off_req;
    int          cur_level;
    int          cur_delay;

    button_debounce_autorepeat #(
        .NUM_BUTTONS (bda_pkg::RAW_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .raw_buttons   (raw_buttons),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pressed_mask  (pressed_mask),
        .released_mask (released_mask),
        .held_mask     (held_mask),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit quiet_window();
        return cycle_count >= 500 && cycle_count < 1000;
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_tick(raw_buttons);
            if (out_valid && out_ready)
                sb.check_tick(pressed_mask, released_mask, held_mask);
        end
    end

    // receiver side, including the one long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_ready <= quiet_window() || ($urandom_range(0, 99) >= 16);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
                || !rst_n)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAIL button_debounce_autorepeat");
        $finish;
    end

    task send_item(input logic [bda_pkg::RAW_W-1:0] v);
        @(negedge clk);
        while (!quiet_window() && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        raw_buttons <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task hold_pattern(input logic [bda_pkg::RAW_W-1:0] v, input int n);
        repeat (n) send_item(v);
    endtask

    task play_run(input int longest);
        int                        n;
        int                        b;
        logic [bda_pkg::RAW_W-1:0] pat;
        logic [bda_pkg::RAW_W-1:0] v;
        n = $urandom_range(1, longest);
        if ($urandom_range(0, 99) < 15)
            repeat (n) send_item(raw_t'($urandom_range(0, 15)));
        else
        begin
            pat = ($urandom_range(0, 3) == 0) ? NONE_PRESSED : raw_t'($urandom_range(0, 15));
            repeat (n)
            begin
                v = pat;
                if ($urandom_range(0, 99) < 8)
                begin
                    b = $urandom_range(0, bda_pkg::RAW_W - 1);
                    v[b] = ~v[b];
                end
                send_item(v);
            end
        end
    endtask

    // wait until every transfer has produced its result
    task settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task write_reg(input logic [bda_pkg::CFG_IDX_W-1:0] idx,
                   input logic [bda_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            bda_pkg::CFG_DEBOUNCE_LEVEL: cur_level = int'(data[bda_pkg::LEVEL_W-1:0]);
            bda_pkg::CFG_REPEAT_DELAY:   cur_delay = int'(data);
            default: ;
        endcase
    endtask

    task close_cfg();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                          phase;
        int                          start;
        int                          phase_len;
        int                          longest;
        bit                          write_all;
        logic [bda_pkg::LEVEL_W-1:0] lvl;
        logic [bda_pkg::COUNT_W-1:0] dly;
        logic [bda_pkg::COUNT_W-1:0] rld;

        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        raw_buttons  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = bda_pkg::CFG_DEBOUNCE_LEVEL;
        cfg_data     = '0;
        items_sent   = 0;
        cycle_count  = 0;
        hold_off_req = 1'b0;
        cur_level    = int'(bda_pkg::LEVEL_RESET);
        cur_delay    = int'(bda_pkg::DELAY_RESET);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings
        send_item(NONE_PRESSED);
        hold_pattern(ALL_PRESSED, 2);
        send_item(NONE_PRESSED);
        settle();

        // short level with masked upper data bits, quick repeats, ignored index
        write_reg(bda_pkg::CFG_DEBOUNCE_LEVEL, 16'hAB02);
        write_reg(bda_pkg::CFG_REPEAT_DELAY, 16'd2);
        write_reg(bda_pkg::CFG_REPEAT_RELOAD, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        close_cfg();
        hold_pattern(ALL_PRESSED, 6);
        hold_pattern(NONE_PRESSED, 3);
        send_item(4'h5);
        hold_pattern(4'hA, 2);
        settle();

        // zero level and zero delay
        write_reg(bda_pkg::CFG_DEBOUNCE_LEVEL, 16'd0);
        write_reg(bda_pkg::CFG_REPEAT_DELAY, 16'd0);
        write_reg(bda_pkg::CFG_REPEAT_RELOAD, 16'd5);
        close_cfg();
        send_item(ALL_PRESSED);
        send_item(NONE_PRESSED);
        send_item(4'h9);
        settle();

        // reload above delay, then level lowered under the integrators
        write_reg(bda_pkg::CFG_DEBOUNCE_LEVEL, 16'd3);
        write_reg(bda_pkg::CFG_REPEAT_DELAY, 16'd1);
        write_reg(bda_pkg::CFG_REPEAT_RELOAD, 16'hFFFF);
        close_cfg();
        hold_pattern(ALL_PRESSED, 4);
        settle();
        write_reg(bda_pkg::CFG_DEBOUNCE_LEVEL, 16'd1);
        close_cfg();
        send_item(NONE_PRESSED);
        send_item(ALL_PRESSED);

        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            phase++;
            settle();
            write_all = (phase == 1) || (phase == 3);
            if (phase == 3)
            begin
                lvl = 8'd255;
                dly = 16'd0;
                rld = 16'hFFFF;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                lvl = $urandom_range(0, 1) ? 8'd0 : 8'd1;
                dly = $urandom_range(0, 1) ? 16'd0 : 16'hFFFF;
                rld = $urandom_range(0, 1) ? 16'd0 : 16'hFFFF;
            end
            else
            begin
                lvl = level_t'($urandom_range(1, 6));
                dly = count_t'($urandom_range(0, 12));
                rld = count_t'($urandom_range(0, dly + 3));
            end
            if (write_all || $urandom_range(0, 3) != 0)
                write_reg(bda_pkg::CFG_DEBOUNCE_LEVEL, {8'($urandom_range(0, 255)), lvl});
            if (write_all || $urandom_range(0, 3) != 0)
                write_reg(bda_pkg::CFG_REPEAT_DELAY, dly);
            if (write_all || $urandom_range(0, 3) != 0)
                write_reg(bda_pkg::CFG_REPEAT_RELOAD, rld);
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
            close_cfg();

            if (phase == 2)
                hold_off_req = 1'b1;
            longest   = cur_level + ((cur_delay > 24) ? 24 : cur_delay) + 6;
            phase_len = (phase == 3) ? 330 : $urandom_range(40, 110);
            start     = items_sent;
            if (phase == 3)
                hold_pattern(ALL_PRESSED, 260);
            while (items_sent - start < phase_len)
                play_run(longest);
        end

        settle();
        repeat (5) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("PASS button_debounce_autorepeat");
        else
            $display("FAIL button_debounce_autorepeat");
        $finish;
    end

endmodule
